FILE: hw/rtl/gsa_pkg.sv
// shared widths, codes and word types of the generational slot allocator
`timescale 1ns / 1ps

package gsa_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 12;
    localparam int GEN_W   = 32;
    localparam int KEY_W   = 32;
    localparam int BUS_W   = 4;
    localparam int PRIO_W  = 8;
    localparam int GAIN_W  = 16;
    localparam int FRAME_W = 64;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 13;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_STALE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    // request word
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   slot_index;
        logic [GEN_W-1:0]   slot_gen;
        logic [KEY_W-1:0]   clip_key;
        logic [BUS_W-1:0]   bus_id;
        logic [KEY_W-1:0]   owner_key;
        logic [PRIO_W-1:0]  prio;
        logic               looping;
        logic [GAIN_W-1:0]  gain_in;
        logic [FRAME_W-1:0] frame_stamp;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [IDX_W-1:0]   out_index;
        logic [GEN_W-1:0]   out_gen;
        logic [CNT_W-1:0]   live_count;
        logic [KEY_W-1:0]   rec_clip;
        logic [BUS_W-1:0]   rec_bus;
        logic [KEY_W-1:0]   rec_owner;
        logic [PRIO_W-1:0]  rec_prio;
        logic               rec_loop;
        logic [GAIN_W-1:0]  rec_gain;
        logic [FRAME_W-1:0] rec_frame;
    } t_out_word;

    // stored request record of one slot
    typedef struct packed {
        logic [KEY_W-1:0]   clip;
        logic [BUS_W-1:0]   bus;
        logic [KEY_W-1:0]   owner;
        logic [PRIO_W-1:0]  prio;
        logic               loop;
        logic [GAIN_W-1:0]  gain;
        logic [FRAME_W-1:0] frame;
    } t_rec;

endpackage

FILE: hw/rtl/gsa_if.sv
// request and result channel interfaces of the slot allocator
`timescale 1ns / 1ps

interface gsa_in_if;
    logic                          valid;
    logic                          ready;
    logic [gsa_pkg::CMD_W-1:0]     cmd;
    logic [gsa_pkg::IDX_W-1:0]     slot_index;
    logic [gsa_pkg::GEN_W-1:0]     slot_gen;
    logic [gsa_pkg::KEY_W-1:0]     clip_key;
    logic [gsa_pkg::BUS_W-1:0]     bus_id;
    logic [gsa_pkg::KEY_W-1:0]     owner_key;
    logic [gsa_pkg::PRIO_W-1:0]    prio;
    logic                          looping;
    logic [gsa_pkg::GAIN_W-1:0]    gain_in;
    logic [gsa_pkg::FRAME_W-1:0]   frame_stamp;

    modport source (
        output valid, cmd, slot_index, slot_gen, clip_key, bus_id, owner_key, prio,
               looping, gain_in, frame_stamp,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot_index, slot_gen, clip_key, bus_id, owner_key, prio,
               looping, gain_in, frame_stamp,
        output ready
    );
endinterface

interface gsa_out_if;
    logic                          valid;
    logic                          ready;
    logic [gsa_pkg::STAT_W-1:0]    status;
    logic [gsa_pkg::IDX_W-1:0]     out_index;
    logic [gsa_pkg::GEN_W-1:0]     out_gen;
    logic [gsa_pkg::CNT_W-1:0]     live_count;
    logic [gsa_pkg::KEY_W-1:0]     rec_clip;
    logic [gsa_pkg::BUS_W-1:0]     rec_bus;
    logic [gsa_pkg::KEY_W-1:0]     rec_owner;
    logic [gsa_pkg::PRIO_W-1:0]    rec_prio;
    logic                          rec_loop;
    logic [gsa_pkg::GAIN_W-1:0]    rec_gain;
    logic [gsa_pkg::FRAME_W-1:0]   rec_frame;

    modport source (
        output valid, status, out_index, out_gen, live_count, rec_clip, rec_bus,
               rec_owner, rec_prio, rec_loop, rec_gain, rec_frame,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_gen, live_count, rec_clip, rec_bus,
               rec_owner, rec_prio, rec_loop, rec_gain, rec_frame,
        output ready
    );
endinterface

FILE: hw/rtl/gsa_ctrl.sv
// control state machine: request capture, execute step and result word handshake
`timescale 1ns / 1ps

module gsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output gsa_pkg::t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;

    // handshake and command decode
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_out_valid  = r_out_valid;
        o_cmd.capture = i_in_valid && (r_state == S_IDLE);
        o_cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/gsa_dpath.sv
// datapath: slot, free list and record memories, counters and result register
`timescale 1ns / 1ps

module gsa_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gsa_pkg::t_ctrl_cmd i_cmd,
    input  gsa_pkg::t_in_word  i_word,
    output gsa_pkg::t_out_word o_word
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_C = AW'(CAPACITY - 1);

    typedef struct packed {
        logic                      live;
        logic [gsa_pkg::GEN_W-1:0] gen;
    } t_slot;

    typedef struct packed {
        logic [AW-1:0]             idx;
        logic [gsa_pkg::GEN_W-1:0] gen;
    } t_fifo_ent;

    // memories
    t_slot         slot_mem [CAPACITY];
    t_fifo_ent     fifo_mem [CAPACITY];
    gsa_pkg::t_rec rec_mem  [CAPACITY];

    // captured request and registered read data
    gsa_pkg::t_in_word  r_in;
    t_slot              r_slot_rd;
    t_fifo_ent          r_fifo_rd;
    gsa_pkg::t_rec      r_rec_rd;
    gsa_pkg::t_out_word r_out;
    gsa_pkg::t_out_word n_out;

    // free list pointers and counters
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [CW-1:0] r_live, n_live;

    // write ports
    logic          w_slot_we;
    logic [AW-1:0] w_slot_addr;
    t_slot         w_slot_data;
    logic          w_fifo_we;
    t_fifo_ent     w_fifo_data;
    logic          w_rec_we;
    gsa_pkg::t_rec w_rec_data;

    // decode helpers
    logic [AW-1:0]             w_rd_addr;
    logic [AW-1:0]             w_idx;
    logic                      w_hdl_ok;
    logic                      w_is_new;
    logic [AW-1:0]             w_acq_slot;
    logic [gsa_pkg::GEN_W-1:0] w_old_gen;
    logic [gsa_pkg::GEN_W-1:0] w_inc_gen;
    logic [gsa_pkg::GEN_W-1:0] w_new_gen;

    assign w_rd_addr = i_word.slot_index[AW-1:0];
    assign w_idx     = r_in.slot_index[AW-1:0];

    // memory reads on capture, writes on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in      <= i_word;
            r_slot_rd <= slot_mem[w_rd_addr];
            r_rec_rd  <= rec_mem[w_rd_addr];
            r_fifo_rd <= fifo_mem[r_head];
        end
        if (w_slot_we) begin
            slot_mem[w_slot_addr] <= w_slot_data;
        end
        if (w_fifo_we) begin
            fifo_mem[r_tail] <= w_fifo_data;
        end
        if (w_rec_we) begin
            rec_mem[w_slot_addr] <= w_rec_data;
        end
    end

    // handle check: slots at or above the fresh count were never acquired
    always_comb begin
        w_hdl_ok = (r_in.slot_gen != '0)
            && ({1'b0, r_in.slot_index} < gsa_pkg::CNT_W'(CAPACITY))
            && ({1'b0, r_in.slot_index} < gsa_pkg::CNT_W'(r_fresh))
            && r_slot_rd.live
            && (r_slot_rd.gen == r_in.slot_gen);
    end

    // acquire slot: the first pass over the table hands out slots in order
    always_comb begin
        w_is_new   = (r_fresh < CAP_C);
        w_acq_slot = w_is_new ? r_fresh[AW-1:0] : r_fifo_rd.idx;
        w_old_gen  = w_is_new ? '0 : r_fifo_rd.gen;
        w_inc_gen  = w_old_gen + gsa_pkg::GEN_W'(1);
        w_new_gen  = (w_inc_gen == '0) ? gsa_pkg::GEN_W'(1) : w_inc_gen;
    end

    // execute step
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_fresh = r_fresh;
        n_live = r_live;
        n_out = '0;
        w_slot_we = 1'b0;
        w_slot_addr = w_idx;
        w_slot_data = '0;
        w_fifo_we = 1'b0;
        w_fifo_data = '0;
        w_rec_we = 1'b0;
        w_rec_data.clip  = r_in.clip_key;
        w_rec_data.bus   = r_in.bus_id;
        w_rec_data.owner = r_in.owner_key;
        w_rec_data.prio  = r_in.prio;
        w_rec_data.loop  = r_in.looping;
        w_rec_data.gain  = r_in.gain_in;
        w_rec_data.frame = r_in.frame_stamp;

        case (r_in.cmd)
            gsa_pkg::CMD_ACQUIRE: begin
                if (r_fill == '0) begin
                    n_out.status = gsa_pkg::STAT_FULL;
                end else begin
                    w_slot_we        = i_cmd.commit;
                    w_rec_we         = i_cmd.commit;
                    w_slot_addr      = w_acq_slot;
                    w_slot_data.live = 1'b1;
                    w_slot_data.gen  = w_new_gen;
                    n_head  = (r_head == LAST_C) ? '0 : r_head + AW'(1);
                    n_fill  = r_fill - CW'(1);
                    n_fresh = w_is_new ? r_fresh + CW'(1) : r_fresh;
                    n_live  = (r_live < CAP_C) ? r_live + CW'(1) : r_live;
                    n_out.status    = gsa_pkg::STAT_OK;
                    n_out.out_index = gsa_pkg::IDX_W'(w_acq_slot);
                    n_out.out_gen   = w_new_gen;
                end
            end
            gsa_pkg::CMD_RELEASE: begin
                if (!w_hdl_ok) begin
                    n_out.status = gsa_pkg::STAT_STALE;
                end else begin
                    w_slot_we        = i_cmd.commit;
                    w_slot_data.live = 1'b0;
                    w_slot_data.gen  = r_slot_rd.gen;
                    // free list full cannot occur in a consistent table
                    if (r_fill < CAP_C) begin
                        w_fifo_we       = i_cmd.commit;
                        w_fifo_data.idx = w_idx;
                        w_fifo_data.gen = r_slot_rd.gen;
                        n_tail = (r_tail == LAST_C) ? '0 : r_tail + AW'(1);
                        n_fill = r_fill + CW'(1);
                    end
                    n_live = (r_live != '0) ? r_live - CW'(1) : r_live;
                    n_out.status = gsa_pkg::STAT_OK;
                end
            end
            gsa_pkg::CMD_LOOKUP: begin
                if (!w_hdl_ok) begin
                    n_out.status = gsa_pkg::STAT_STALE;
                end else begin
                    n_out.status    = gsa_pkg::STAT_OK;
                    n_out.rec_clip  = r_rec_rd.clip;
                    n_out.rec_bus   = r_rec_rd.bus;
                    n_out.rec_owner = r_rec_rd.owner;
                    n_out.rec_prio  = r_rec_rd.prio;
                    n_out.rec_loop  = r_rec_rd.loop;
                    n_out.rec_gain  = r_rec_rd.gain;
                    n_out.rec_frame = r_rec_rd.frame;
                end
            end
            default: begin
                n_out.status = gsa_pkg::STAT_STALE;
            end
        endcase

        n_out.live_count = gsa_pkg::CNT_W'(n_live);
    end

    // counters advance on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= CAP_C;
            r_fresh <= '0;
            r_live  <= '0;
        end else if (i_cmd.commit) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_fresh <= n_fresh;
            r_live  <= n_live;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

FILE: hw/rtl/generational_slot_allocator.sv
// Generational slot allocator top level: controller, datapath and channel ports.
// A request word is captured with its memory reads; the execute step then writes the
// result register, waiting only while the previous result still waits on the output register.
// No new request is taken until the current one has committed, since the slot memory and
// free list are read synchronously and then written. Reset is synchronous: counters and
// free list restart at once, with no clearing pass over the memories.
`timescale 1ns / 1ps

module generational_slot_allocator #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsa_in_if.sink    i_in,
    gsa_out_if.source o_out
);

    gsa_pkg::t_ctrl_cmd w_cmd;
    gsa_pkg::t_in_word  w_in_word;
    gsa_pkg::t_out_word w_out_word;
    logic               w_in_ready;
    logic               w_out_valid;

    // request word gather
    always_comb begin
        w_in_word.cmd         = i_in.cmd;
        w_in_word.slot_index  = i_in.slot_index;
        w_in_word.slot_gen    = i_in.slot_gen;
        w_in_word.clip_key    = i_in.clip_key;
        w_in_word.bus_id      = i_in.bus_id;
        w_in_word.owner_key   = i_in.owner_key;
        w_in_word.prio        = i_in.prio;
        w_in_word.looping     = i_in.looping;
        w_in_word.gain_in     = i_in.gain_in;
        w_in_word.frame_stamp = i_in.frame_stamp;
    end

    gsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    gsa_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_word  (w_in_word),
        .o_word  (w_out_word)
    );

    // channel drive
    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.status     = w_out_word.status;
    assign o_out.out_index  = w_out_word.out_index;
    assign o_out.out_gen    = w_out_word.out_gen;
    assign o_out.live_count = w_out_word.live_count;
    assign o_out.rec_clip   = w_out_word.rec_clip;
    assign o_out.rec_bus    = w_out_word.rec_bus;
    assign o_out.rec_owner  = w_out_word.rec_owner;
    assign o_out.rec_prio   = w_out_word.rec_prio;
    assign o_out.rec_loop   = w_out_word.rec_loop;
    assign o_out.rec_gain   = w_out_word.rec_gain;
    assign o_out.rec_frame  = w_out_word.rec_frame;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while another is executing");

    // a committed step always presents a result word
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out.valid)
        else $error("committed step without result word");

    // live count never exceeds table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.live_count <= gsa_pkg::CNT_W'(CAPACITY)))
        else $error("live count above capacity");

    // a full report carries no handle
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == gsa_pkg::STAT_FULL))
            |-> ((o_out.out_index == '0) && (o_out.out_gen == '0)))
        else $error("full status with nonzero handle");

endmodule
